@@ hw/rtl/servo_angle_to_pulse_mapper_core_macros.svh @@
// Assertion helpers for the servo pulse mapper.
`ifndef SERVO_ANGLE_TO_PULSE_MAPPER_CORE_MACROS_SVH
`define SERVO_ANGLE_TO_PULSE_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, muted during reset.
`define SAPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted during reset.
`define SAPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/sapm_pkg.sv @@
package sapm_pkg;

	localparam int ANGLE_W = 16;
	localparam int LIM_W   = 15;
	localparam int US_W    = 16;
	localparam int DIFF_W  = US_W + 1;
	localparam int PROD_W  = LIM_W + 1 + DIFF_W;
	localparam int QUO_W   = 17;
	localparam int DIVD_W  = US_W + 1 + QUO_W + 1;
	localparam int N_CELLS = QUO_W;

	localparam logic [LIM_W-1:0] RST_ANGLE_LIMIT = 15'd9000;
	localparam logic [US_W-1:0]  RST_PERIOD      = 16'd20000;
	localparam logic [US_W-1:0]  RST_PULSE_NEG   = 16'd1000;
	localparam logic [US_W-1:0]  RST_PULSE_CTR   = 16'd1500;
	localparam logic [US_W-1:0]  RST_PULSE_POS   = 16'd2000;

	typedef enum logic [2:0] {
		REG_ANGLE_LIMIT = 3'd0,
		REG_PERIOD      = 3'd1,
		REG_PULSE_NEG   = 3'd2,
		REG_PULSE_CTR   = 3'd3,
		REG_PULSE_POS   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0] angle_limit;
		logic [US_W-1:0]  period_len;
		logic [US_W-1:0]  pulse_negative_us;
		logic [US_W-1:0]  pulse_center_us;
		logic [US_W-1:0]  pulse_positive_us;
	} cfg_t;

	// One divider slot: remainder, shifting dividend/quotient word, and passengers.
	typedef struct packed {
		logic             valid;
		logic             ok;
		logic [US_W-1:0]  rem;
		logic [QUO_W-1:0] work;
		logic [US_W-1:0]  den;
		logic [US_W-1:0]  center;
		logic [US_W-1:0]  period;
	} cell_t;

endpackage

@@ hw/rtl/sapm_front.sv @@
module sapm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [sapm_pkg::ANGLE_W-1:0]    steering_angle,
	input  sapm_pkg::cfg_t                         cfg,
	output sapm_pkg::cell_t                        cell_o
);

	logic                                  cfg_ok;
	logic                                  neg;
	logic [sapm_pkg::ANGLE_W-1:0]          mag_raw;
	logic [sapm_pkg::LIM_W-1:0]            mag;
	logic [sapm_pkg::US_W-1:0]             end_us;
	logic signed [sapm_pkg::DIFF_W-1:0]    diff;
	logic [sapm_pkg::US_W-1:0]             den;
	logic [sapm_pkg::DIVD_W:0]             sum_w;

	logic                                  valid_s1, ok_s1;
	logic [sapm_pkg::LIM_W-1:0]            mag_s1;
	logic signed [sapm_pkg::DIFF_W-1:0]    diff_s1;
	logic                                  valid_s2, ok_s2;
	logic signed [sapm_pkg::PROD_W-1:0]    prod_s2;
	sapm_pkg::cell_t                       cell_s3;

	// configuration sanity: nonzero limit/period, pulses in (0, period), strict order
	always_comb begin
		cfg_ok = (cfg.angle_limit != '0) && (cfg.period_len != '0) &&
			(cfg.pulse_negative_us != '0) && (cfg.pulse_center_us != '0) &&
			(cfg.pulse_positive_us != '0) &&
			(cfg.pulse_negative_us < cfg.period_len) &&
			(cfg.pulse_center_us < cfg.period_len) &&
			(cfg.pulse_positive_us < cfg.period_len) &&
			(((cfg.pulse_negative_us < cfg.pulse_center_us) &&
			  (cfg.pulse_center_us < cfg.pulse_positive_us)) ||
			 ((cfg.pulse_negative_us > cfg.pulse_center_us) &&
			  (cfg.pulse_center_us > cfg.pulse_positive_us)));
	end

	// clamp magnitude to the limit, pick the end pulse by sign
	always_comb begin
		neg     = steering_angle[sapm_pkg::ANGLE_W-1];
		mag_raw = neg ? sapm_pkg::ANGLE_W'(-steering_angle) : steering_angle;
		mag     = (mag_raw > {1'b0, cfg.angle_limit}) ? cfg.angle_limit
			: mag_raw[sapm_pkg::LIM_W-1:0];
		end_us  = neg ? cfg.pulse_negative_us : cfg.pulse_positive_us;
		diff    = $signed({1'b0, end_us}) - $signed({1'b0, cfg.pulse_center_us});
	end

	// dividend = 2*mag*diff + limit, biased by den<<16 so it is never negative
	always_comb begin
		den   = {cfg.angle_limit, 1'b0};
		sum_w = {{2{prod_s2[sapm_pkg::PROD_W-1]}}, prod_s2, 1'b0}
			+ (sapm_pkg::DIVD_W+1)'(cfg.angle_limit)
			+ (sapm_pkg::DIVD_W+1)'({den, 16'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			cell_s3        <= '0;
		end else if (en) begin
			valid_s1       <= in_valid;
			valid_s2       <= valid_s1;
			cell_s3.valid  <= valid_s2;
			cell_s3.ok     <= ok_s2;
			cell_s3.rem    <= sum_w[sapm_pkg::QUO_W+sapm_pkg::US_W-1:sapm_pkg::QUO_W];
			cell_s3.work   <= sum_w[sapm_pkg::QUO_W-1:0];
			cell_s3.den    <= den;
			cell_s3.center <= cfg.pulse_center_us;
			cell_s3.period <= cfg.period_len;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1          <= cfg_ok;
			mag_s1         <= mag;
			diff_s1        <= diff;
			ok_s2          <= ok_s1;
			prod_s2        <= sapm_pkg::PROD_W'($signed({1'b0, mag_s1}))
				* sapm_pkg::PROD_W'(diff_s1);
		end
	end

	assign cell_o = cell_s3;

endmodule

@@ hw/rtl/sapm_cell.sv @@
module sapm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sapm_pkg::cell_t d,
	output sapm_pkg::cell_t q
);

	logic [sapm_pkg::US_W:0]   trial;
	logic [sapm_pkg::US_W:0]   sub;
	logic                      ge;
	sapm_pkg::cell_t           nxt;
	sapm_pkg::cell_t           slot_q;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {d.rem, d.work[sapm_pkg::QUO_W-1]};
		sub   = trial - {1'b0, d.den};
		ge    = trial >= {1'b0, d.den};
		nxt   = d;
		nxt.rem  = ge ? sub[sapm_pkg::US_W-1:0] : trial[sapm_pkg::US_W-1:0];
		nxt.work = {d.work[sapm_pkg::QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (en) begin
			slot_q <= nxt;
		end
	end

	assign q = slot_q;

endmodule

@@ hw/rtl/servo_angle_to_pulse_mapper_core.sv @@
// Servo angle to pulse mapper. Takes a signed steering angle (hundredths of a
// degree), clamps it to +/- angle_limit and returns the PWM period and a pulse
// width interpolated from the center pulse toward the negative or positive end,
// rounded half up. One request is accepted per cycle while the output is not
// stalled; its result passes through clamp, multiply, dividend build, a chain of
// 17 divider cells that each settle one quotient bit, and the output register.
// A stalled output freezes the whole pipeline. A bad configuration gives ok=0
// with zero period and pulse. The user must write configuration only while no
// request is in flight; the block itself does not enforce this.
`include "servo_angle_to_pulse_mapper_core_macros.svh"

module servo_angle_to_pulse_mapper_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [sapm_pkg::US_W-1:0]           cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sapm_pkg::ANGLE_W-1:0] steering_angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [sapm_pkg::US_W-1:0]           out_period_us,
	output logic [sapm_pkg::US_W-1:0]           pulse_width
);

	sapm_pkg::cfg_t               cfg_q;
	sapm_pkg::cell_t              chain [0:sapm_pkg::N_CELLS];
	logic                         adv;
	logic                         out_valid_q, ok_q;
	logic [sapm_pkg::US_W-1:0]    period_q, pulse_q;
	logic [sapm_pkg::US_W-1:0]    pulse_calc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_limit       <= sapm_pkg::RST_ANGLE_LIMIT;
			cfg_q.period_len        <= sapm_pkg::RST_PERIOD;
			cfg_q.pulse_negative_us <= sapm_pkg::RST_PULSE_NEG;
			cfg_q.pulse_center_us   <= sapm_pkg::RST_PULSE_CTR;
			cfg_q.pulse_positive_us <= sapm_pkg::RST_PULSE_POS;
		end else if (cfg_we) begin
			case (cfg_index)
				sapm_pkg::REG_ANGLE_LIMIT:
					cfg_q.angle_limit <= cfg_wdata[sapm_pkg::LIM_W-1:0];
				sapm_pkg::REG_PERIOD:    cfg_q.period_len        <= cfg_wdata;
				sapm_pkg::REG_PULSE_NEG: cfg_q.pulse_negative_us <= cfg_wdata;
				sapm_pkg::REG_PULSE_CTR: cfg_q.pulse_center_us   <= cfg_wdata;
				sapm_pkg::REG_PULSE_POS: cfg_q.pulse_positive_us <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless a finished result is held
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	sapm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (adv),
		.in_valid       (in_valid),
		.steering_angle (steering_angle),
		.cfg            (cfg_q),
		.cell_o         (chain[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < sapm_pkg::N_CELLS; i++) begin : g_cell
		sapm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// quotient carries a +65536 bias that drops out modulo 2^16
	assign pulse_calc = chain[sapm_pkg::N_CELLS].center
		+ chain[sapm_pkg::N_CELLS].work[sapm_pkg::US_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[sapm_pkg::N_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q     <= chain[sapm_pkg::N_CELLS].ok;
			period_q <= chain[sapm_pkg::N_CELLS].ok ? chain[sapm_pkg::N_CELLS].period : '0;
			pulse_q  <= chain[sapm_pkg::N_CELLS].ok ? pulse_calc : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign out_period_us  = period_q;
	assign pulse_width    = pulse_q;

	// a rejected config must never leak a nonzero field
	`SAPM_ASSERT_NOW(a_bad_cfg_zero, out_valid && !ok,
		out_period_us == '0 && pulse_width == '0, "nonzero output with ok low")
	// a good result lies strictly between zero and the period
	`SAPM_ASSERT_NOW(a_pulse_range, out_valid && ok,
		pulse_width != '0 && pulse_width < out_period_us, "pulse out of range")
	// a held result blocks new requests
	`SAPM_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
		"request taken while output stalled")
	// the last cell's request lands in the output register
	`SAPM_ASSERT_NEXT(a_chain_to_out, adv && chain[sapm_pkg::N_CELLS].valid, out_valid,
		"result lost at output register")

endmodule
